// ===== src/ibal_pkg.sv =====
// Shared types and constants for the inode and block allocator.
// Depends on nothing; inode_block_allocator_core imports it.
package ibal_pkg;

    localparam int ACTION_W = 2;
    localparam int INDEX_W  = 10;
    localparam int STATUS_W = 2;
    localparam int INUM_W   = 7;
    localparam int BNUM_W   = 10;

    typedef enum logic [1:0] {
        ACT_ALLOC_INODE = 2'd0,
        ACT_FREE_INODE  = 2'd1,
        ACT_ALLOC_BLOCK = 2'd2,
        ACT_FREE_BLOCK  = 2'd3
    } action_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK       = 2'd0,
        STAT_NO_INODE = 2'd1,
        STAT_NO_BLOCK = 2'd2,
        STAT_NO_DATA  = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_IREF_RD,
        S_IREF_CHK,
        S_IALLOC_RD,
        S_IALLOC_WR,
        S_BREF_RD,
        S_BREF_CHK,
        S_TAKE,
        S_IFREE_RD,
        S_IFREE_WR,
        S_GRP_RD,
        S_GRP_CHK,
        S_DONE
    } state_t;

endpackage

// ===== src/ibal_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module ibal_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== src/ibal_stack.sv =====
// Small LIFO cache of free numbers; pushes beyond CAP are dropped.
// Depends on nothing.
module ibal_stack #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int CAP   = 16,
    localparam int CW  = $clog2(DEPTH + 1),
    localparam int DAW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] top,
    output logic [CW-1:0]    count
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [CW-1:0]    count_reg;
    logic [CW-1:0]    count_next;
    logic [CW-1:0]    top_idx;
    logic             push_ok;

    assign top_idx = count_reg - CW'(1);
    assign top     = mem[top_idx[DAW-1:0]];
    assign count   = count_reg;
    assign push_ok = push && (count_reg < CW'(CAP));

    always_comb
    begin
        count_next = count_reg;
        if (push_ok)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (pop && (count_reg != '0))
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_ok)
        begin
            mem[count_reg[DAW-1:0]] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

endmodule

// ===== src/inode_block_allocator_core.sv =====
// Top level of the inode and block allocator: sequencer, stacks and memories.
// Depends on ibal_pkg, ibal_ram and ibal_stack.
//
// Usage: one request beat (action, index) on the in channel gives exactly one
// result beat (status, inode_number, block_number) on the out channel.
// The block works on one request at a time; in_ready is high only while it
// waits for a request. A block free goes straight to the done state; a block
// allocation from a non-empty cache passes through the take state, and an inode
// allocation with both caches non-empty reads and rewrites the inode entry first.
// An inode free with its index out of range ends after its read state; otherwise
// it scans the group until an inode in use is found or the group ends. An empty
// inode cache adds a refill scan that reads and checks each inode; an empty block
// cache adds a scan that reads and checks each block of the used-block memory.
// These scans over the single read port of each memory set the item time, and
// the block returns to its idle state after each result before taking the next.
// After reset the block runs a clearing pass over max(BLOCK_COUNT, INODE_COUNT)
// addresses of both memories, with in_ready low, before the first beat.
// The result sits in an output register; while the receiver stalls it holds
// there and the next request is not finished until the result is taken.
module inode_block_allocator_core
    import ibal_pkg::*;
#(
    parameter int BLOCK_COUNT       = 1024,
    parameter int INODE_AREA_BLOCKS = 16,
    parameter int INODES_PER_BLOCK  = 8,
    parameter int INODE_CACHE_DEPTH = 16,
    parameter int BLOCK_CACHE_DEPTH = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [ACTION_W-1:0] action,
    input  logic [INDEX_W-1:0]  index,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [STATUS_W-1:0] status,
    output logic [INUM_W-1:0]   inode_number,
    output logic [BNUM_W-1:0]   block_number
);

    localparam int INODE_COUNT = INODE_AREA_BLOCKS * INODES_PER_BLOCK;
    localparam int INODE_CAP   = (INODE_CACHE_DEPTH > INODE_COUNT) ?
                                 INODE_COUNT / 2 : INODE_CACHE_DEPTH;
    localparam int BW   = $clog2(BLOCK_COUNT);
    localparam int IW   = (INODE_COUNT > 1) ? $clog2(INODE_COUNT) : 1;
    localparam int AW   = $clog2(INODE_AREA_BLOCKS + 2);
    localparam int PW   = $clog2(INODES_PER_BLOCK + 1);
    localparam int CLEAR_N  = (BLOCK_COUNT > INODE_COUNT) ? BLOCK_COUNT : INODE_COUNT;
    localparam int SCAN_MAX = (BLOCK_COUNT > INODE_COUNT + INODES_PER_BLOCK) ?
                              BLOCK_COUNT : INODE_COUNT + INODES_PER_BLOCK;
    localparam int SW   = $clog2(SCAN_MAX + 1);
    localparam int EW   = 2 + BW + AW;
    localparam int ICW  = $clog2(INODE_CACHE_DEPTH + 1);
    localparam int BCW  = $clog2(BLOCK_CACHE_DEPTH + 1);
    // Inode entry layout: in-use bit, empty marker, attached block, area block.
    localparam int E_USE   = EW - 1;
    localparam int E_EMPTY = EW - 2;

    state_t                state_reg, state_next;
    logic [ACTION_W-1:0]   action_reg;
    logic [INDEX_W-1:0]    index_reg;
    logic [SW-1:0]         scan_reg;
    logic [SW-1:0]         last_reg;
    logic [SW-1:0]         clr_addr_reg;
    logic [AW-1:0]         clr_area_reg;
    logic [PW-1:0]         clr_pos_reg;
    logic [IW-1:0]         inum_reg;
    logic [BW-1:0]         blk_reg;
    logic [STATUS_W-1:0]   status_reg;
    logic [AW-1:0]         area_reg;
    logic                  out_valid_reg;
    logic [STATUS_W-1:0]   status_out_reg;
    logic [INUM_W-1:0]     inum_out_reg;
    logic [BNUM_W-1:0]     blk_out_reg;

    // Memory and stack controls.
    logic                  b_we;
    logic [BW-1:0]         b_waddr, b_raddr;
    logic [0:0]            b_wdata, b_rdata;
    logic                  i_we;
    logic [IW-1:0]         i_waddr, i_raddr;
    logic [EW-1:0]         i_wdata, i_rdata;
    logic                  is_push, is_pop, bs_push, bs_pop;
    logic [IW-1:0]         is_data, is_top;
    logic [BW-1:0]         bs_data, bs_top;
    logic [ICW-1:0]        is_count;
    logic [BCW-1:0]        bs_count;

    logic                  in_acc;
    logic                  out_free;
    logic                  idx_inode_ok;
    logic                  idx_block_ok;
    logic [AW-1:0]         rd_area;
    logic [BW-1:0]         rd_blk;
    logic [SW-1:0]         grp_first;

    assign in_ready     = (state_reg == S_IDLE);
    assign in_acc       = in_valid && in_ready;
    assign out_free     = !out_valid_reg || out_ready;
    assign out_valid    = out_valid_reg;
    assign status       = status_out_reg;
    assign inode_number = inum_out_reg;
    assign block_number = blk_out_reg;

    assign idx_inode_ok = (index_reg != '0) &&
                          (32'(index_reg) < 32'(INODE_COUNT));
    assign idx_block_ok = 32'(index) < 32'(BLOCK_COUNT);
    assign rd_area      = i_rdata[AW-1:0];
    assign rd_blk       = i_rdata[BW+AW-1:AW];
    // First inode of the group held by an inode-area block.
    assign grp_first    = SW'(rd_area - AW'(1)) * SW'(INODES_PER_BLOCK) + SW'(1);

    ibal_ram #(.WIDTH(1), .DEPTH(BLOCK_COUNT)) u_bmap (
        .clk   (clk),
        .we    (b_we),
        .waddr (b_waddr),
        .wdata (b_wdata),
        .raddr (b_raddr),
        .rdata (b_rdata)
    );

    ibal_ram #(.WIDTH(EW), .DEPTH(INODE_COUNT)) u_inode (
        .clk   (clk),
        .we    (i_we),
        .waddr (i_waddr),
        .wdata (i_wdata),
        .raddr (i_raddr),
        .rdata (i_rdata)
    );

    ibal_stack #(.WIDTH(IW), .DEPTH(INODE_CACHE_DEPTH), .CAP(INODE_CAP)) u_istack (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (is_push),
        .push_data (is_data),
        .pop       (is_pop),
        .top       (is_top),
        .count     (is_count)
    );

    ibal_stack #(.WIDTH(BW), .DEPTH(BLOCK_CACHE_DEPTH), .CAP(BLOCK_CACHE_DEPTH)) u_bstack (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (bs_push),
        .push_data (bs_data),
        .pop       (bs_pop),
        .top       (bs_top),
        .count     (bs_count)
    );

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (clr_addr_reg == SW'(CLEAR_N - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_acc)
                begin
                    unique case (action_t'(action))
                        ACT_ALLOC_INODE:
                            state_next = (is_count == '0) ? S_IREF_RD : S_IALLOC_RD;
                        ACT_FREE_INODE:  state_next = S_IFREE_RD;
                        ACT_ALLOC_BLOCK:
                            state_next = (bs_count == '0) ? S_BREF_RD : S_TAKE;
                        ACT_FREE_BLOCK:  state_next = S_DONE;
                        default:         state_next = S_DONE;
                    endcase
                end
            end
            S_IREF_RD:
            begin
                if ((scan_reg >= SW'(INODE_COUNT)) || (is_count >= ICW'(INODE_CAP)))
                begin
                    state_next = (is_count == '0) ? S_DONE : S_IALLOC_RD;
                end
                else
                begin
                    state_next = S_IREF_CHK;
                end
            end
            S_IREF_CHK:  state_next = S_IREF_RD;
            S_IALLOC_RD: state_next = S_IALLOC_WR;
            S_IALLOC_WR: state_next = (bs_count == '0) ? S_BREF_RD : S_TAKE;
            S_BREF_RD:
            begin
                if ((scan_reg >= SW'(BLOCK_COUNT)) ||
                    (bs_count >= BCW'(BLOCK_CACHE_DEPTH)))
                begin
                    state_next = (bs_count == '0) ? S_DONE : S_TAKE;
                end
                else
                begin
                    state_next = S_BREF_CHK;
                end
            end
            S_BREF_CHK: state_next = S_BREF_RD;
            S_TAKE:     state_next = S_DONE;
            S_IFREE_RD: state_next = idx_inode_ok ? S_IFREE_WR : S_DONE;
            S_IFREE_WR: state_next = S_GRP_RD;
            S_GRP_RD:
            begin
                if ((scan_reg >= last_reg) || (scan_reg >= SW'(INODE_COUNT)))
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_GRP_CHK;
                end
            end
            S_GRP_CHK:
            begin
                state_next = i_rdata[E_USE] ? S_DONE : S_GRP_RD;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Memory and stack controls.
    always_comb
    begin
        b_we    = 1'b0;
        b_waddr = scan_reg[BW-1:0];
        b_wdata = 1'b0;
        b_raddr = scan_reg[BW-1:0];
        i_we    = 1'b0;
        i_waddr = scan_reg[IW-1:0];
        i_wdata = '0;
        i_raddr = scan_reg[IW-1:0];
        is_push = 1'b0;
        is_data = scan_reg[IW-1:0];
        is_pop  = 1'b0;
        bs_push = 1'b0;
        bs_data = scan_reg[BW-1:0];
        bs_pop  = 1'b0;
        unique case (state_reg)
            S_CLEAR:
            begin
                b_we    = clr_addr_reg < SW'(BLOCK_COUNT);
                b_waddr = clr_addr_reg[BW-1:0];
                i_we    = clr_addr_reg < SW'(INODE_COUNT);
                i_waddr = clr_addr_reg[IW-1:0];
                i_wdata[E_EMPTY] = 1'b1;
                i_wdata[AW-1:0]  = (clr_addr_reg == '0) ? '0 : clr_area_reg;
            end
            S_IDLE:
            begin
                // A block free completes here: push and mark unused.
                if (in_acc && (action_t'(action) == ACT_FREE_BLOCK) && idx_block_ok)
                begin
                    bs_push = 1'b1;
                    bs_data = BW'(index);
                    b_we    = 1'b1;
                    b_waddr = BW'(index);
                end
            end
            S_IREF_RD:  ;
            S_IREF_CHK:
            begin
                is_push = !i_rdata[E_USE];
            end
            S_IALLOC_RD:
            begin
                is_pop  = 1'b1;
                i_raddr = is_top;
            end
            S_IALLOC_WR:
            begin
                b_we    = 32'(rd_area) < 32'(BLOCK_COUNT);
                b_waddr = BW'(rd_area);
                b_wdata = 1'b1;
                i_we    = 1'b1;
                i_waddr = inum_reg;
                i_wdata = {1'b1, 1'b1, BW'(0), rd_area};
            end
            S_BREF_RD:  ;
            S_BREF_CHK:
            begin
                bs_push = !b_rdata[0];
            end
            S_TAKE:
            begin
                bs_pop  = 1'b1;
                b_we    = 1'b1;
                b_waddr = bs_top;
                b_wdata = 1'b1;
                if (action_t'(action_reg) == ACT_ALLOC_INODE)
                begin
                    i_we    = 1'b1;
                    i_waddr = inum_reg;
                    i_wdata = {1'b1, 1'b0, bs_top, area_reg};
                end
            end
            S_IFREE_RD:
            begin
                is_push = idx_inode_ok;
                is_data = IW'(index_reg);
                i_raddr = IW'(index_reg);
            end
            S_IFREE_WR:
            begin
                i_we    = 1'b1;
                i_waddr = IW'(index_reg);
                i_wdata = {1'b0, 1'b1, BW'(0), rd_area};
                if (!i_rdata[E_EMPTY])
                begin
                    bs_push = 1'b1;
                    bs_data = rd_blk;
                    b_we    = 1'b1;
                    b_waddr = rd_blk;
                end
            end
            S_GRP_RD:
            begin
                // Whole group free: release its inode-area block.
                if (((scan_reg >= last_reg) || (scan_reg >= SW'(INODE_COUNT))) &&
                    (32'(area_reg) < 32'(BLOCK_COUNT)))
                begin
                    b_we    = 1'b1;
                    b_waddr = BW'(area_reg);
                end
            end
            S_GRP_CHK:  ;
            S_DONE:     ;
            default:    ;
        endcase
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                action_reg <= action;
                index_reg  <= index;
                status_reg <= STAT_OK;
                inum_reg   <= '0;
                blk_reg    <= '0;
                if (action_t'(action) == ACT_ALLOC_INODE)
                begin
                    scan_reg <= SW'(1);
                end
                else
                begin
                    scan_reg <= SW'(INODE_AREA_BLOCKS + 1);
                end
            end
            S_IREF_RD:
            begin
                if (((scan_reg >= SW'(INODE_COUNT)) || (is_count >= ICW'(INODE_CAP))) &&
                    (is_count == '0))
                begin
                    status_reg <= STAT_NO_INODE;
                end
            end
            S_IREF_CHK:  scan_reg <= scan_reg + SW'(1);
            S_IALLOC_RD: inum_reg <= is_top;
            S_IALLOC_WR:
            begin
                area_reg <= rd_area;
                scan_reg <= SW'(INODE_AREA_BLOCKS + 1);
            end
            S_BREF_RD:
            begin
                if (((scan_reg >= SW'(BLOCK_COUNT)) ||
                     (bs_count >= BCW'(BLOCK_CACHE_DEPTH))) && (bs_count == '0))
                begin
                    status_reg <= (action_t'(action_reg) == ACT_ALLOC_INODE) ?
                                  STAT_NO_DATA : STAT_NO_BLOCK;
                end
            end
            S_BREF_CHK:  scan_reg <= scan_reg + SW'(1);
            S_TAKE:      blk_reg  <= bs_top;
            S_IFREE_WR:
            begin
                area_reg <= rd_area;
                scan_reg <= grp_first;
                last_reg <= grp_first + SW'(INODES_PER_BLOCK);
            end
            S_GRP_CHK:   scan_reg <= scan_reg + SW'(1);
            default:     ;
        endcase
        if (state_reg == S_DONE && out_free)
        begin
            status_out_reg <= status_reg;
            inum_out_reg   <= INUM_W'(inum_reg);
            blk_out_reg    <= BNUM_W'(blk_reg);
        end
    end

    // Control registers: state, clearing pass counters, output valid.
    // The clearing pass walks its own address counter up from zero.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            out_valid_reg <= 1'b0;
            clr_addr_reg  <= '0;
            clr_area_reg  <= AW'(1);
            clr_pos_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_DONE && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (state_reg == S_CLEAR)
            begin
                clr_addr_reg <= clr_addr_reg + SW'(1);
            end
            if (state_reg == S_CLEAR && clr_addr_reg != '0)
            begin
                if (clr_pos_reg == PW'(INODES_PER_BLOCK - 1))
                begin
                    clr_pos_reg  <= '0;
                    clr_area_reg <= clr_area_reg + AW'(1);
                end
                else
                begin
                    clr_pos_reg <= clr_pos_reg + PW'(1);
                end
            end
        end
    end

endmodule

// ===== tb/tb_inode_block_allocator_core.sv =====
// Self-checking testbench for the inode and block allocator core.
// Depends on ibal_pkg and inode_block_allocator_core; runs directed and random beats.
module tb_inode_block_allocator_core;
    import ibal_pkg::*;

    localparam int NBLK    = 1024;
    localparam int NAREA   = 16;
    localparam int PERGRP  = 8;
    localparam int NINODE  = NAREA * PERGRP;
    localparam int IDEPTH  = 16;
    localparam int BDEPTH  = 16;
    localparam int ICAP    = (IDEPTH > NINODE) ? NINODE / 2 : IDEPTH;
    localparam int NO_DATA = 32'h10000;
    localparam int CYCLE_LIMIT = 10000000;

    typedef struct packed {
        logic [STATUS_W-1:0] st;
        logic [INUM_W-1:0]   inum;
        logic [BNUM_W-1:0]   bnum;
    } alloc_result_t;

    // Scoreboard: keeps a shadow of the allocator state and a queue of expected results.
    class alloc_scoreboard;
        bit            used_map[NBLK];
        bit            in_use[NINODE];
        int unsigned   data_blk[NINODE];
        int unsigned   istack[IDEPTH];
        int unsigned   icount;
        int unsigned   bstack[BDEPTH];
        int unsigned   bcount;
        alloc_result_t pending[$];
        int            errors;
        int            checked;

        function new();
            for (int i = 0; i < NINODE; i++)
            begin
                data_blk[i] = NO_DATA;
            end
        endfunction

        function bit take_block(output int unsigned blk);
            if (bcount == 0)
            begin
                for (int b = NAREA + 1; b < NBLK && bcount < BDEPTH; b++)
                begin
                    if (!used_map[b])
                    begin
                        bstack[bcount] = b;
                        bcount++;
                    end
                end
                if (bcount == 0)
                    return 0;
            end
            bcount--;
            blk = bstack[bcount];
            if (blk < NBLK)
                used_map[blk] = 1;
            return 1;
        endfunction

        function void release_block(int unsigned blk);
            if (blk >= NBLK)
                return;
            if (bcount < BDEPTH)
            begin
                bstack[bcount] = blk;
                bcount++;
            end
            used_map[blk] = 0;
        endfunction

        // Called for every accepted request beat.
        function void note_request(action_t act, logic [INDEX_W-1:0] idx);
            alloc_result_t r;
            int unsigned   blk;
            int unsigned   n;
            int unsigned   first;
            int unsigned   area;
            bit            all_free;
            r = '0;
            n = idx;
            case (act)
                ACT_ALLOC_INODE:
                begin
                    if (icount == 0)
                    begin
                        for (int i = 1; i < NINODE && icount < ICAP; i++)
                        begin
                            if (!in_use[i])
                            begin
                                istack[icount] = i;
                                icount++;
                            end
                        end
                    end
                    if (icount == 0)
                    begin
                        r.st = STAT_NO_INODE;
                    end
                    else
                    begin
                        icount--;
                        n = istack[icount];
                        r.inum = INUM_W'(n);
                        area = (n - 1) / PERGRP + 1;
                        if (area < NBLK)
                            used_map[area] = 1;
                        in_use[n] = 1;
                        if (take_block(blk))
                        begin
                            data_blk[n] = blk;
                            r.bnum = BNUM_W'(blk);
                        end
                        else
                        begin
                            data_blk[n] = NO_DATA;
                            r.st = STAT_NO_DATA;
                        end
                    end
                end
                ACT_FREE_INODE:
                begin
                    if (n != 0 && n < NINODE)
                    begin
                        if (icount < ICAP)
                        begin
                            istack[icount] = n;
                            icount++;
                        end
                        in_use[n] = 0;
                        if ((data_blk[n] & NO_DATA) == 0)
                        begin
                            release_block(data_blk[n]);
                            data_blk[n] = NO_DATA;
                        end
                        first = n - ((n - 1) % PERGRP);
                        all_free = 1;
                        for (int i = first; i < first + PERGRP; i++)
                        begin
                            if (i < NINODE && in_use[i])
                                all_free = 0;
                        end
                        area = (n - 1) / PERGRP + 1;
                        if (all_free && area < NBLK)
                            used_map[area] = 0;
                    end
                end
                ACT_ALLOC_BLOCK:
                begin
                    if (take_block(blk))
                        r.bnum = BNUM_W'(blk);
                    else
                        r.st = STAT_NO_BLOCK;
                end
                default:
                begin
                    release_block(n);
                end
            endcase
            pending = {pending, r};
        endfunction

        // Called for every accepted result beat; returns a mismatch message or "".
        function string check_result(alloc_result_t got);
            alloc_result_t want;
            checked++;
            if (pending.size() == 0)
                return "result beat with nothing expected";
            want = pending.pop_front();
            if (got.st !== want.st)
                return $sformatf("status got %0d want %0d", got.st, want.st);
            if (got.inum !== want.inum)
                return $sformatf("inode_number got %0d want %0d", got.inum, want.inum);
            if (got.bnum !== want.bnum)
                return $sformatf("block_number got %0d want %0d", got.bnum, want.bnum);
            return "";
        endfunction
    endclass

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    logic [ACTION_W-1:0] action;
    logic [INDEX_W-1:0]  index;
    logic                out_valid;
    logic                out_ready;
    logic [STATUS_W-1:0] status;
    logic [INUM_W-1:0]   inode_number;
    logic [BNUM_W-1:0]   block_number;

    alloc_scoreboard sb;
    int  mismatches;
    int  cycles;
    bit  calm;          // no idling on either side in the final part
    int  sent;

    inode_block_allocator_core i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .action       (action),
        .index        (index),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .inode_number (inode_number),
        .block_number (block_number)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #10 clk = ~clk;

    task automatic report_mismatch(string msg);
        mismatches++;
        $display("mismatch at cycle %0d: %s", cycles, msg);
    endtask

    // The scoreboard is updated at the rising edge at which a beat moves, so
    // prediction always follows acceptance order.
    always @(posedge clk)
    begin
        string msg;
        if (rst_n)
        begin
            cycles <= cycles + 1;
            if (in_valid && in_ready)
                sb.note_request(action_t'(action), index);
            if (out_valid && out_ready)
            begin
                msg = sb.check_result({status, inode_number, block_number});
                if (msg != "")
                    report_mismatch(msg);
            end
        end
    end

    // Receiver stalls come in bursts, changed only at the falling edge.
    initial
    begin
        int gap;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!calm && $urandom_range(0, 9) == 0)
            begin
                gap = $urandom_range(1, 12);
                out_ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            out_ready <= 1'b1;
        end
    end

    // Sends one request beat and holds it until it is taken. The caller drops
    // in_valid after the last beat.
    task automatic send_request(action_t act, logic [INDEX_W-1:0] idx);
        int gap;
        if (!calm && $urandom_range(0, 7) == 0)
        begin
            gap = $urandom_range(1, 12);
            in_valid <= 1'b0;
            action   <= ACTION_W'($urandom_range(0, 3));
            index    <= INDEX_W'($urandom_range(0, 1023));
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        action   <= act;
        index    <= idx;
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
        sent++;
    endtask

    // Picks an index for a free: mostly live or in-range numbers, sometimes anything.
    function automatic logic [INDEX_W-1:0] pick_inode();
        int k;
        k = $urandom_range(0, 9);
        if (k < 7)
            return INDEX_W'($urandom_range(1, NINODE - 1));
        return INDEX_W'($urandom_range(0, 1023));
    endfunction

    initial
    begin
        int      k;
        cycles     = 0;
        mismatches = 0;
        calm       = 0;
        sent       = 0;
        sb         = new();
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        action     = ACT_ALLOC_INODE;
        index      = '0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part: every action, out-of-range frees, field extremes.
        send_request(ACT_ALLOC_INODE, 10'd0);
        send_request(ACT_ALLOC_INODE, 10'h3FF);
        send_request(ACT_ALLOC_BLOCK, 10'd0);
        send_request(ACT_FREE_BLOCK, 10'd0);
        send_request(ACT_FREE_BLOCK, 10'd5);
        send_request(ACT_FREE_BLOCK, 10'h3FF);
        send_request(ACT_FREE_INODE, 10'd0);
        send_request(ACT_FREE_INODE, 10'd128);
        send_request(ACT_FREE_INODE, 10'h3FF);
        send_request(ACT_FREE_INODE, 10'd127);
        send_request(ACT_FREE_INODE, 10'd16);
        send_request(ACT_FREE_INODE, 10'd15);
        send_request(ACT_FREE_INODE, 10'd1);
        send_request(ACT_ALLOC_INODE, 10'd0);
        for (int i = 0; i < 20; i++)
            send_request(ACT_FREE_BLOCK, INDEX_W'(17 + i));
        send_request(ACT_ALLOC_BLOCK, 10'h155);

        // Random part. Phases bias toward exhausting inodes and blocks so the
        // no-inode, no-block and inode-without-block statuses all appear.
        for (int n = 0; n < 800; n++)
        begin
            if (n > 680)
                calm = 1;
            k = $urandom_range(0, 99);
            if ((n / 200) % 2 == 0)
            begin
                if (k < 45)
                    send_request(ACT_ALLOC_INODE, INDEX_W'($urandom_range(0, 1023)));
                else if (k < 80)
                    send_request(ACT_ALLOC_BLOCK, INDEX_W'($urandom_range(0, 1023)));
                else if (k < 92)
                    send_request(ACT_FREE_INODE, pick_inode());
                else
                    send_request(ACT_FREE_BLOCK, INDEX_W'($urandom_range(0, 1023)));
            end
            else
            begin
                if (k < 40)
                    send_request(ACT_FREE_INODE, pick_inode());
                else if (k < 70)
                    send_request(ACT_FREE_BLOCK, INDEX_W'($urandom_range(0, 1023)));
                else if (k < 85)
                    send_request(ACT_ALLOC_INODE, INDEX_W'($urandom_range(0, 1023)));
                else
                    send_request(ACT_ALLOC_BLOCK, INDEX_W'($urandom_range(0, 1023)));
            end
        end
        in_valid <= 1'b0;

        while (sb.pending.size() != 0 && cycles < CYCLE_LIMIT)
            @(posedge clk);
        repeat (50) @(posedge clk);

        $display("Sent %0d request beats and checked %0d result beats,", sent, sb.checked);
        $display("covering every action, stack refills and exhausted caches.");
        if (mismatches == 0 && sb.pending.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // Watchdog, generous against scan-heavy requests and long stalls.
    initial
    begin
        wait (cycles >= CYCLE_LIMIT);
        $display("timeout after %0d cycles", cycles);
        $display("FAILED: results differ");
        $finish;
    end

endmodule
